// ----- hw/rtl/mesh_vertex_normal_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator: assertion macros
// Shared property shorthands for the accumulator's checks.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, inactive while reset is low
`define MVNA_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive while reset is low
`define MVNA_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mvna_pkg.sv -----
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator package
// Widths, request codes, sequencer states and small helpers.
// ----------------------------------------------------------------------------
package mvna_pkg;

    localparam int MAX_VERTS        = 1024;
    localparam int VIDX_W           = $clog2(MAX_VERTS);
    localparam int COORD_BITS       = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int SUM_BITS         = 24;
    localparam int GUARD            = 7;
    localparam int EDGE_LIM         = 30;
    localparam int NRM_LIM          = 24;
    localparam int NRM_W            = 16;
    localparam int EXT_W            = COORD_BITS - 1;
    localparam int DIFF_W           = COORD_BITS + 1;
    localparam int DSH_W            = EDGE_LIM + 1;
    localparam int PROD_W           = 2 * DSH_W;
    localparam int CR_W             = PROD_W + 1;
    localparam int SS_W             = 2 * NRM_LIM + 2;
    localparam int X_W              = SS_W + 2 * GUARD;
    localparam int LEN_W            = X_W / 2;
    localparam int Q_W              = NORMAL_FRAC_BITS + 1;
    localparam int NUM_W            = NRM_LIM + NORMAL_FRAC_BITS + GUARD + 1;
    localparam int QCNT_W           = $clog2(Q_W);

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_TRI   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_LOAD,
        S_VRD,
        S_DIFF,
        S_DSHR,
        S_MUL,
        S_ZCHK,
        S_NRD,
        S_NRDW,
        S_NSHR,
        S_SQ,
        S_SQRT,
        S_DIV,
        S_ARD,
        S_AWT,
        S_EXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // operand selects for the six cross product terms
    function automatic logic [2:0] mul_sel_a(logic [2:0] k);
        logic [2:0] r;
        unique case (k)
            3'd0:    r = 3'd1;
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd0;
            3'd4:    r = 3'd0;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mul_sel_b(logic [2:0] k);
        logic [2:0] r;
        unique case (k)
            3'd0:    r = 3'd5;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd3;
            3'd3:    r = 3'd5;
            3'd4:    r = 3'd4;
            default: r = 3'd3;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/mesh_vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator
// Keeps vertex coordinates and per-vertex sums of unit face normals, returns
// normalised vertex normals and tracks the bounding box half extent.
// ----------------------------------------------------------------------------
// One request is handled at a time; the input side is not ready until the
// result has been written to the output register. The time of a normal read
// and of an added triangle is set by the shared square root unit, the
// divider run once per component, a pre-normalising shift of one bit per
// cycle for large cross products, and the six products through the single
// shared multiplier. A clear request, and likewise reset, sweeps the normal
// sum memory one entry per cycle; no request is taken during that sweep
// after reset.
module mesh_vertex_normal_accumulator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_req_type,
    input  logic [mvna_pkg::VIDX_W-1:0]            i_vert_index,
    input  logic signed [mvna_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [mvna_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic signed [mvna_pkg::COORD_BITS-1:0] i_coord_z,
    input  logic [mvna_pkg::VIDX_W-1:0]            i_corner_a,
    input  logic [mvna_pkg::VIDX_W-1:0]            i_corner_b,
    input  logic [mvna_pkg::VIDX_W-1:0]            i_corner_c,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [mvna_pkg::NRM_W-1:0]      o_normal_x,
    output logic signed [mvna_pkg::NRM_W-1:0]      o_normal_y,
    output logic signed [mvna_pkg::NRM_W-1:0]      o_normal_z,
    output logic [mvna_pkg::EXT_W-1:0]             o_half_extent,
    output logic                                   o_degenerate
);
    import mvna_pkg::*;
    `include "mesh_vertex_normal_accumulator_defines.svh"

    localparam logic [VIDX_W-1:0] LAST_VERT = VIDX_W'(MAX_VERTS - 1);
    localparam logic [Q_W-1:0]    Q_MAX     = Q_W'(1) << NORMAL_FRAC_BITS;

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        logic signed [SUM_BITS-1:0] a,
        logic signed [NRM_W-1:0]    b
    );
        logic signed [SUM_BITS:0] s;
        s = (SUM_BITS + 1)'(a) + (SUM_BITS + 1)'(b);
        if (s[SUM_BITS] != s[SUM_BITS-1]) begin
            return s[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                               : {1'b0, {(SUM_BITS - 1){1'b1}}};
        end
        return s[SUM_BITS-1:0];
    endfunction

    function automatic logic [CR_W-1:0] abs_cr(logic signed [CR_W-1:0] v);
        return v[CR_W-1] ? CR_W'(-v) : CR_W'(v);
    endfunction

    // control
    t_state              r_state, n_state;
    logic [2:0]          r_cnt, n_cnt;
    logic                r_sub, n_sub;
    logic [VIDX_W-1:0]   r_caddr, n_caddr;
    logic                r_clr_rsp;
    logic                r_loaded;
    logic signed [COORD_BITS-1:0] r_lo [3];
    logic signed [COORD_BITS-1:0] r_hi [3];
    logic                r_ovalid;
    logic                in_ready;
    logic                out_load;

    // request payload
    t_req                r_req;
    logic [VIDX_W-1:0]   r_vi;
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic [VIDX_W-1:0]   r_corner [3];

    // datapath
    logic [3*COORD_BITS-1:0]  r_pt [3];
    logic                     r_dneg [6];
    logic [DIFF_W-1:0]        r_dmag [6];
    logic signed [PROD_W-1:0] r_prod, r_acc;
    logic signed [CR_W-1:0]   r_cr [3];
    logic                     r_vneg [3];
    logic [CR_W-1:0]          r_vmag [3];
    logic [SS_W-1:0]          r_ss;
    logic [LEN_W-1:0]         r_len;
    logic signed [NRM_W-1:0]  r_u [3];
    logic                     r_degen;
    logic [COORD_BITS-1:0]    r_edge;

    // output register
    logic signed [NRM_W-1:0]  r_onx, r_ony, r_onz;
    logic [EXT_W-1:0]         r_ohalf;
    logic                     r_odegen;

    // memories
    logic                     vram_we, vram_re;
    logic [VIDX_W-1:0]        vram_raddr;
    logic [3*COORD_BITS-1:0]  vram_rdata;
    logic                     nram_we, nram_re;
    logic [VIDX_W-1:0]        nram_waddr, nram_raddr;
    logic [3*SUM_BITS-1:0]    nram_wdata, nram_rdata;

    // shared units
    logic                     sqrt_start, div_start;
    t_unit_stat               sqrt_stat, div_stat;
    logic [LEN_W-1:0]         sqrt_root;
    logic [Q_W-1:0]           div_q;
    logic [NUM_W-1:0]         div_num;

    // combinational helpers
    logic signed [DSH_W-1:0]  d_s [6];
    logic signed [DSH_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     d_big, v_big, cr_zero, sum_zero;
    logic [VIDX_W-1:0]        corner_sel;
    logic [CR_W-1:0]          vmag_sel;
    logic signed [COORD_BITS-1:0] hi_sel, lo_sel;
    logic signed [DIFF_W-1:0] edge_d;
    t_state                   after_div;

    mvna_ram #(.WIDTH(3 * COORD_BITS), .DEPTH(MAX_VERTS)) u_vram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (r_vi),
        .i_wdata ({r_cx, r_cy, r_cz}),
        .i_re    (vram_re),
        .i_raddr (vram_raddr),
        .o_rdata (vram_rdata)
    );

    mvna_ram #(.WIDTH(3 * SUM_BITS), .DEPTH(MAX_VERTS)) u_nram (
        .i_clk   (i_clk),
        .i_we    (nram_we),
        .i_waddr (nram_waddr),
        .i_wdata (nram_wdata),
        .i_re    (nram_re),
        .i_raddr (nram_raddr),
        .o_rdata (nram_rdata)
    );

    mvna_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     ({r_ss, {(2 * GUARD){1'b0}}}),
        .o_stat  (sqrt_stat),
        .o_root  (sqrt_root)
    );

    mvna_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_len),
        .o_stat  (div_stat),
        .o_quot  (div_q)
    );

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            d_s[k] = r_dneg[k] ? -$signed(DSH_W'(r_dmag[k])) : $signed(DSH_W'(r_dmag[k]));
        end
        d_big = 1'b0;
        for (int k = 0; k < 6; k++) begin
            d_big = d_big | (|r_dmag[k][DIFF_W-1:EDGE_LIM]);
        end
        v_big    = 1'b0;
        cr_zero  = 1'b1;
        sum_zero = (nram_rdata == '0);
        for (int k = 0; k < 3; k++) begin
            v_big   = v_big | (|r_vmag[k][CR_W-1:NRM_LIM]);
            cr_zero = cr_zero & (r_cr[k] == '0);
        end

        unique case (r_cnt)
            3'd0:    corner_sel = r_corner[0];
            3'd1:    corner_sel = r_corner[1];
            default: corner_sel = r_corner[2];
        endcase
        unique case (r_cnt)
            3'd0:    vmag_sel = r_vmag[0];
            3'd1:    vmag_sel = r_vmag[1];
            default: vmag_sel = r_vmag[2];
        endcase
        unique case (r_cnt)
            3'd0: begin
                hi_sel = r_hi[0];
                lo_sel = r_lo[0];
            end
            3'd1: begin
                hi_sel = r_hi[1];
                lo_sel = r_lo[1];
            end
            default: begin
                hi_sel = r_hi[2];
                lo_sel = r_lo[2];
            end
        endcase
        edge_d = DIFF_W'(hi_sel) - DIFF_W'(lo_sel);

        if (r_state == S_SQ) begin
            mul_a = $signed(DSH_W'(vmag_sel[NRM_LIM-1:0]));
            mul_b = mul_a;
        end else begin
            mul_a = d_s[mul_sel_a(r_cnt)];
            mul_b = d_s[mul_sel_b(r_cnt)];
        end
        mul_p = mul_a * mul_b;

        div_num = (NUM_W'(vmag_sel[NRM_LIM-1:0]) << (NORMAL_FRAC_BITS + GUARD))
                  + NUM_W'(r_len >> 1);
        after_div = (r_req == REQ_TRI) ? S_ARD : S_EXT;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sub      = r_sub;
        n_caddr    = r_caddr;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        vram_we    = 1'b0;
        vram_re    = 1'b0;
        vram_raddr = corner_sel;
        nram_we    = 1'b0;
        nram_re    = 1'b0;
        nram_waddr = r_caddr;
        nram_raddr = r_vi;
        nram_wdata = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                nram_we = 1'b1;
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == LAST_VERT) begin
                    n_cnt   = '0;
                    n_state = r_clr_rsp ? S_EXT : S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cnt = '0;
                    unique case (t_req'(i_req_type))
                        REQ_LOAD:  n_state = S_LOAD;
                        REQ_TRI:   n_state = S_VRD;
                        REQ_READ:  n_state = S_NRD;
                        REQ_CLEAR: begin
                            n_caddr = '0;
                            n_state = S_CLR;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                vram_we = 1'b1;
                n_state = S_EXT;
            end
            S_VRD: begin
                if (r_cnt == 3'd3) begin
                    n_state = S_DIFF;
                end else begin
                    vram_re = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            S_DIFF: n_state = S_DSHR;
            S_DSHR: begin
                if (!d_big) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd6) begin
                    n_state = S_ZCHK;
                end
            end
            S_ZCHK: begin
                n_cnt   = '0;
                n_state = cr_zero ? S_EXT : S_NSHR;
            end
            S_NRD: begin
                nram_re = 1'b1;
                n_state = S_NRDW;
            end
            S_NRDW: begin
                n_cnt   = '0;
                n_state = sum_zero ? S_EXT : S_NSHR;
            end
            S_NSHR: begin
                if (!v_big) begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd3) begin
                    n_sub   = 1'b0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!r_sub) begin
                    sqrt_start = 1'b1;
                    n_sub      = 1'b1;
                end else if (sqrt_stat.done) begin
                    n_sub   = 1'b0;
                    n_cnt   = '0;
                    n_state = (sqrt_root == '0) ? after_div : S_DIV;
                end
            end
            S_DIV: begin
                if (!r_sub) begin
                    div_start = 1'b1;
                    n_sub     = 1'b1;
                end else if (div_stat.done) begin
                    n_sub = 1'b0;
                    if (r_cnt == 3'd2) begin
                        n_cnt   = '0;
                        n_state = after_div;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_ARD: begin
                nram_re    = 1'b1;
                nram_raddr = corner_sel;
                n_state    = S_AWT;
            end
            S_AWT: begin
                nram_we    = 1'b1;
                nram_waddr = corner_sel;
                for (int a = 0; a < 3; a++) begin
                    nram_wdata[(2 - a) * SUM_BITS +: SUM_BITS] =
                        sat_add($signed(nram_rdata[(2 - a) * SUM_BITS +: SUM_BITS]), r_u[a]);
                end
                if (r_cnt == 3'd2) begin
                    n_cnt   = '0;
                    n_state = S_EXT;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_ARD;
                end
            end
            S_EXT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_sub     <= 1'b0;
            r_caddr   <= '0;
            r_clr_rsp <= 1'b0;
            r_loaded  <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sub   <= n_sub;
            r_caddr <= n_caddr;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (in_ready && i_in_valid && t_req'(i_req_type) == REQ_CLEAR) begin
                r_clr_rsp <= 1'b1;
                r_loaded  <= 1'b0;
                for (int a = 0; a < 3; a++) begin
                    r_lo[a] <= '0;
                    r_hi[a] <= '0;
                end
            end
            if (r_state == S_LOAD) begin
                r_loaded <= 1'b1;
                for (int a = 0; a < 3; a++) begin
                    // grow only: a new vertex widens at most one side per axis
                    if (!r_loaded) begin
                        r_lo[a] <= (a == 0) ? r_cx : ((a == 1) ? r_cy : r_cz);
                        r_hi[a] <= (a == 0) ? r_cx : ((a == 1) ? r_cy : r_cz);
                    end else if (((a == 0) ? r_cx : ((a == 1) ? r_cy : r_cz)) > r_hi[a]) begin
                        r_hi[a] <= (a == 0) ? r_cx : ((a == 1) ? r_cy : r_cz);
                    end else if (((a == 0) ? r_cx : ((a == 1) ? r_cy : r_cz)) < r_lo[a]) begin
                        r_lo[a] <= (a == 0) ? r_cx : ((a == 1) ? r_cy : r_cz);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_ready && i_in_valid) begin
            r_req       <= t_req'(i_req_type);
            r_vi        <= i_vert_index;
            r_cx        <= i_coord_x;
            r_cy        <= i_coord_y;
            r_cz        <= i_coord_z;
            r_corner[0] <= i_corner_a;
            r_corner[1] <= i_corner_b;
            r_corner[2] <= i_corner_c;
            r_degen     <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_u[a] <= '0;
            end
        end
        unique case (r_state)
            S_VRD: begin
                if (r_cnt == 3'd1) begin
                    r_pt[0] <= vram_rdata;
                end else if (r_cnt == 3'd2) begin
                    r_pt[1] <= vram_rdata;
                end else if (r_cnt == 3'd3) begin
                    r_pt[2] <= vram_rdata;
                end
            end
            S_DIFF: begin
                for (int a = 0; a < 3; a++) begin
                    r_dneg[a] <= (DIFF_W'($signed(r_pt[1][(2 - a) * COORD_BITS +: COORD_BITS]))
                        - DIFF_W'($signed(r_pt[0][(2 - a) * COORD_BITS +: COORD_BITS])))
                        >= 0 ? 1'b0 : 1'b1;
                    r_dneg[a + 3] <= (DIFF_W'($signed(r_pt[2][(2 - a) * COORD_BITS +: COORD_BITS]))
                        - DIFF_W'($signed(r_pt[0][(2 - a) * COORD_BITS +: COORD_BITS])))
                        >= 0 ? 1'b0 : 1'b1;
                end
                for (int a = 0; a < 3; a++) begin
                    logic signed [DIFF_W-1:0] db, dc;
                    db = DIFF_W'($signed(r_pt[1][(2 - a) * COORD_BITS +: COORD_BITS]))
                         - DIFF_W'($signed(r_pt[0][(2 - a) * COORD_BITS +: COORD_BITS]));
                    dc = DIFF_W'($signed(r_pt[2][(2 - a) * COORD_BITS +: COORD_BITS]))
                         - DIFF_W'($signed(r_pt[0][(2 - a) * COORD_BITS +: COORD_BITS]));
                    r_dmag[a]     <= db[DIFF_W-1] ? DIFF_W'(-db) : DIFF_W'(db);
                    r_dmag[a + 3] <= dc[DIFF_W-1] ? DIFF_W'(-dc) : DIFF_W'(dc);
                end
            end
            S_DSHR: begin
                // truncate toward zero: shift magnitudes, keep signs
                if (d_big) begin
                    for (int k = 0; k < 6; k++) begin
                        r_dmag[k] <= r_dmag[k] >> 1;
                    end
                end
            end
            S_MUL: begin
                unique case (r_cnt)
                    3'd1, 3'd3, 3'd5: r_acc   <= r_prod;
                    3'd2:             r_cr[0] <= CR_W'(r_acc) - CR_W'(r_prod);
                    3'd4:             r_cr[1] <= CR_W'(r_acc) - CR_W'(r_prod);
                    3'd6:             r_cr[2] <= CR_W'(r_acc) - CR_W'(r_prod);
                    default: ;
                endcase
            end
            S_ZCHK: begin
                if (cr_zero) begin
                    r_degen <= 1'b1;
                end
                for (int a = 0; a < 3; a++) begin
                    r_vneg[a] <= r_cr[a][CR_W-1];
                    r_vmag[a] <= abs_cr(r_cr[a]);
                end
            end
            S_NRDW: begin
                for (int a = 0; a < 3; a++) begin
                    r_vneg[a] <= nram_rdata[(3 - a) * SUM_BITS - 1];
                    r_vmag[a] <= abs_cr(CR_W'($signed(nram_rdata[(2 - a) * SUM_BITS +: SUM_BITS])));
                end
            end
            S_NSHR: begin
                if (v_big) begin
                    for (int a = 0; a < 3; a++) begin
                        r_vmag[a] <= r_vmag[a] >> 1;
                    end
                end
            end
            S_SQ: begin
                if (r_cnt == 3'd0) begin
                    r_ss <= '0;
                end else begin
                    r_ss <= r_ss + SS_W'(r_prod[2*NRM_LIM-1:0]);
                end
            end
            S_SQRT: begin
                if (r_sub && sqrt_stat.done) begin
                    r_len <= sqrt_root;
                end
            end
            S_DIV: begin
                if (r_sub && div_stat.done) begin
                    unique case (r_cnt)
                        3'd0: r_u[0] <= r_vneg[0] ? -$signed(NRM_W'(div_q)) : $signed(NRM_W'(div_q));
                        3'd1: r_u[1] <= r_vneg[1] ? -$signed(NRM_W'(div_q)) : $signed(NRM_W'(div_q));
                        default: r_u[2] <= r_vneg[2] ? -$signed(NRM_W'(div_q))
                                                     : $signed(NRM_W'(div_q));
                    endcase
                end
            end
            S_EXT: begin
                if (r_cnt == 3'd0) begin
                    r_edge <= edge_d[DIFF_W-1] ? '0 : edge_d[COORD_BITS-1:0];
                end else if (!edge_d[DIFF_W-1] && edge_d[COORD_BITS-1:0] > r_edge) begin
                    r_edge <= edge_d[COORD_BITS-1:0];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_onx    <= (r_req == REQ_READ) ? r_u[0] : '0;
            r_ony    <= (r_req == REQ_READ) ? r_u[1] : '0;
            r_onz    <= (r_req == REQ_READ) ? r_u[2] : '0;
            r_ohalf  <= r_edge[COORD_BITS-1:1];
            r_odegen <= r_degen;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_ovalid;
    assign o_normal_x    = r_onx;
    assign o_normal_y    = r_ony;
    assign o_normal_z    = r_onz;
    assign o_half_extent = r_ohalf;
    assign o_degenerate  = r_odegen;

    `MVNA_AST_NXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready, "ready held after an input transfer")
    `MVNA_AST_IMP(a_degen_zero_normal, o_out_valid && o_degenerate, o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0, "degenerate result with non-zero normal")
    `MVNA_AST_IMP(a_quot_bound, div_stat.done, div_q <= Q_MAX, "normal component above unit range")
    `MVNA_AST_IMP(a_sqrt_start_idle, sqrt_start, !sqrt_stat.busy, "square root started while busy")

endmodule

// ----- hw/rtl/mvna_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/mvna_sqrt.sv -----
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mvna_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mvna_pkg::X_W-1:0]      i_x,
    output mvna_pkg::t_unit_stat          o_stat,
    output logic [mvna_pkg::LEN_W-1:0]    o_root
);
    import mvna_pkg::*;

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [X_W-1:0] r_x, n_x;
    logic [X_W-1:0] r_r, n_r;
    logic [X_W-1:0] r_bit, n_bit;
    logic [X_W-1:0] trial;

    always_comb begin
        trial  = r_r + r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_x    = r_x;
        n_r    = r_r;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_x    = i_x;
            n_r    = '0;
            n_bit  = X_W'(1) << (X_W - 2);
        end else if (r_busy) begin
            if (r_x >= trial) begin
                n_x = r_x - trial;
                n_r = (r_r >> 1) + r_bit;
            end else begin
                n_r = r_r >> 1;
            end
            n_bit = r_bit >> 2;
            if ((r_bit >> 2) == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_r   <= n_r;
        r_bit <= n_bit;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_r[LEN_W-1:0];

endmodule

// ----- hw/rtl/mvna_div.sv -----
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces a short quotient, one bit per cycle, for a numerator known to be
// below the denominator scaled by the quotient range.
// ----------------------------------------------------------------------------
module mvna_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mvna_pkg::NUM_W-1:0]    i_num,
    input  logic [mvna_pkg::LEN_W-1:0]    i_den,
    output mvna_pkg::t_unit_stat          o_stat,
    output logic [mvna_pkg::Q_W-1:0]      o_quot
);
    import mvna_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_dsh, n_dsh;
    logic [Q_W-1:0]    r_q, n_q;
    logic              ge;

    always_comb begin
        ge     = r_rem >= r_dsh;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = QCNT_W'(Q_W - 1);
            n_rem  = i_num;
            n_dsh  = NUM_W'(i_den) << (Q_W - 1);
            n_q    = '0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_q   = {r_q[Q_W-2:0], ge};
            n_dsh = r_dsh >> 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule
